>>> rtl/csn_pkg.sv
// csn_pkg: types and constants shared by the neighbour-cell stencil block.
// No dependencies; every rtl file refers to it by scoped names.
package csn_pkg;

  localparam int COORD_W   = 6;
  localparam int GRID_W    = 7;
  localparam int STENCIL_N = 27;
  localparam int CENTRE    = 13;   // offset (0,0,0) in the x-outer, z-inner order

  localparam logic [1:0]        DIM_2D        = 2'd2;
  localparam logic [1:0]        DIM_3D        = 2'd3;
  localparam logic [1:0]        RST_DIMS      = DIM_3D;
  localparam logic [1:0]        RST_PERIODIC  = 2'd0;
  localparam logic [GRID_W-1:0] RST_CELLS     = 7'd3;
  localparam logic [GRID_W-1:0] MIN_CELLS     = 7'd3;

  typedef enum logic [1:0] {
    REG_DIMENSIONS = 2'd0,
    REG_PERIODIC   = 2'd1,
    REG_CELLS      = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        dimensions;
    logic [1:0]        periodic_axes;
    logic [GRID_W-1:0] cells_per_side;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;
  } coord_t;

  typedef struct packed {
    logic [COORD_W-1:0] nbr_x;
    logic [COORD_W-1:0] nbr_y;
    logic [COORD_W-1:0] nbr_z;
    logic               last;
  } nbr_t;

  // One classified centre cell: candidate positions per axis for offsets
  // -1, 0, +1 (index 0, 1, 2) and the set of stencil slots to emit.
  typedef struct packed {
    logic [2:0][COORD_W-1:0] pos_x;
    logic [2:0][COORD_W-1:0] pos_y;
    logic [2:0][COORD_W-1:0] pos_z;
    logic [STENCIL_N-1:0]    mask;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } enq_t;

endpackage

>>> rtl/cell_neighbor_stencil.sv
// cell_neighbor_stencil: neighbour cells of one centre cell in a cubic grid.
// Depends on csn_pkg, csn_regs, csn_front, csn_jobq, csn_back.
//
//   channel   ports                                dir   word
//   config    psel penable pwrite paddr pwdata    in    3 registers at 0x0, 0x4, 0x8
//             prdata pready                        out
//   cells     push full coord                      in    csn_pkg::coord_t
//   nbrs      pop empty nbr                        out   csn_pkg::nbr_t
//
// A centre cell with k neighbours holds the output sequencer until all k have left
// (k up to 26, 8 in 2D); one leaves per cycle while the output register is empty
// or popped, last on the final one.  Cells with no neighbours are dropped.
// Two classified cells queue behind the one in progress; full rises when both
// are taken.  Synchronous reset restores 3D, no wrap, 3 cells per side.
module cell_neighbor_stencil #(
  parameter int MAX_CELLS_PER_SIDE = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             push,
  output logic             full,
  input  csn_pkg::coord_t  coord,
  input  logic             pop,
  output logic             empty,
  output csn_pkg::nbr_t    nbr
);

  csn_pkg::cfg_t  cfg;
  csn_pkg::enq_t  enq;
  csn_pkg::job_t  q_head;
  logic           q_nonempty;
  logic           q_deq;
  logic           accept;

  assign accept = push && !full;

  csn_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csn_front #(
    .MAX_CELLS_PER_SIDE (MAX_CELLS_PER_SIDE)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .coord  (coord),
    .accept (accept),
    .enq    (enq)
  );

  csn_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .enq      (enq),
    .full     (full),
    .nonempty (q_nonempty),
    .head     (q_head),
    .deq      (q_deq)
  );

  csn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_deq      (q_deq),
    .nbr        (nbr),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

>>> rtl/csn_regs.sv
// csn_regs: APB-style register file for grid shape and wrap settings.
// Depends on csn_pkg.
module csn_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output csn_pkg::cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dimensions     <= csn_pkg::RST_DIMS;
      cfg.periodic_axes  <= csn_pkg::RST_PERIODIC;
      cfg.cells_per_side <= csn_pkg::RST_CELLS;
    end else if (wr_en) begin
      case (paddr[3:2])
        csn_pkg::REG_DIMENSIONS: cfg.dimensions     <= pwdata[1:0];
        csn_pkg::REG_PERIODIC:   cfg.periodic_axes  <= pwdata[1:0];
        csn_pkg::REG_CELLS:      cfg.cells_per_side <= pwdata[csn_pkg::GRID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      csn_pkg::REG_DIMENSIONS: prdata[1:0] = cfg.dimensions;
      csn_pkg::REG_PERIODIC:   prdata[1:0] = cfg.periodic_axes;
      csn_pkg::REG_CELLS:      prdata[csn_pkg::GRID_W-1:0] = cfg.cells_per_side;
      default:                 prdata = '0;
    endcase
  end

endmodule

>>> rtl/csn_front.sv
// csn_front: clamps the centre cell into the grid and classifies it into a
// job (per-axis candidate positions plus a mask of stencil slots).
// Depends on csn_pkg.
module csn_front #(
  parameter int MAX_CELLS_PER_SIDE = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  csn_pkg::cfg_t    cfg,
  input  csn_pkg::coord_t  coord,
  input  logic             accept,
  output csn_pkg::enq_t    enq
);

  // The grid register is 7 bits, so any cap above its range does nothing.
  localparam int NCAP = (MAX_CELLS_PER_SIDE > 127) ? 127 : MAX_CELLS_PER_SIDE;
  localparam logic [csn_pkg::GRID_W-1:0] NCAP_W = csn_pkg::GRID_W'(NCAP);

  logic [csn_pkg::GRID_W-1:0]  n_eff;
  logic [csn_pkg::GRID_W-1:0]  nm1;
  logic [2:0][csn_pkg::GRID_W-1:0] centre;
  logic [2:0][2:0][csn_pkg::COORD_W-1:0] pos;
  logic [2:0][2:0]             ok;
  logic [2:0]                  wraps;
  logic                        planar;
  logic                        dims_ok;
  logic [csn_pkg::COORD_W-1:0] raw [3];
  logic [csn_pkg::GRID_W-1:0]  c7;
  logic [csn_pkg::GRID_W-1:0]  dn;
  logic [csn_pkg::GRID_W-1:0]  up;

  always_comb begin
    n_eff = cfg.cells_per_side;
    if (n_eff < csn_pkg::MIN_CELLS) n_eff = csn_pkg::MIN_CELLS;
    if (n_eff > NCAP_W)             n_eff = NCAP_W;
    nm1 = n_eff - csn_pkg::GRID_W'(1);

    dims_ok = cfg.dimensions inside {csn_pkg::DIM_2D, csn_pkg::DIM_3D};
    planar  = (cfg.dimensions == csn_pkg::DIM_2D);

    wraps[0] = (cfg.periodic_axes > 2'd0);
    wraps[1] = (cfg.periodic_axes > 2'd1);
    wraps[2] = (cfg.periodic_axes > 2'd2);

    raw[0] = coord.cell_x;
    raw[1] = coord.cell_y;
    raw[2] = coord.cell_z;

    for (int a = 0; a < 3; a++) begin
      c7 = {1'b0, raw[a]};
      centre[a] = (c7 > nm1) ? nm1 : c7;
      // step past an edge wraps to the far side, or is dropped
      dn = (centre[a] == '0)  ? nm1 : centre[a] - csn_pkg::GRID_W'(1);
      up = (centre[a] == nm1) ? '0  : centre[a] + csn_pkg::GRID_W'(1);
      pos[a][0] = dn[csn_pkg::COORD_W-1:0];
      pos[a][1] = centre[a][csn_pkg::COORD_W-1:0];
      pos[a][2] = up[csn_pkg::COORD_W-1:0];
      ok[a][0]  = (centre[a] != '0)  || wraps[a];
      ok[a][1]  = 1'b1;
      ok[a][2]  = (centre[a] != nm1) || wraps[a];
    end

    // planar grid: z pinned to 0 with only the zero offset
    if (planar) begin
      pos[2] = '0;
      ok[2]  = 3'b010;
    end

    enq.job.pos_x = pos[0];
    enq.job.pos_y = pos[1];
    enq.job.pos_z = pos[2];
    for (int ix = 0; ix < 3; ix++) begin
      for (int iy = 0; iy < 3; iy++) begin
        for (int iz = 0; iz < 3; iz++) begin
          enq.job.mask[ix*9 + iy*3 + iz] = ok[0][ix] && ok[1][iy] && ok[2][iz]
                                           && dims_ok
                                           && ((ix*9 + iy*3 + iz) != csn_pkg::CENTRE);
        end
      end
    end

    // a cell with no neighbours leaves no job behind
    enq.valid = accept && (enq.job.mask != '0);
  end

  a_enq_no_centre: assert property (@(posedge clk) disable iff (rst)
    enq.valid |-> !enq.job.mask[csn_pkg::CENTRE])
    else $error("centre slot queued for emission");

  a_enq_needs_accept: assert property (@(posedge clk) disable iff (rst)
    enq.valid |-> accept && (enq.job.mask != '0))
    else $error("job queued without an accepted word");

endmodule

>>> rtl/csn_jobq.sv
// csn_jobq: two-entry queue of classified jobs between front and back.
// Depends on csn_pkg.
module csn_jobq (
  input  logic            clk,
  input  logic            rst,
  input  csn_pkg::enq_t   enq,
  output logic            full,
  output logic            nonempty,
  output csn_pkg::job_t   head,
  input  logic            deq
);

  csn_pkg::job_t mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign head     = mem[rptr];

  always_comb begin
    count_next = count;
    if (enq.valid && !(deq && nonempty)) count_next = count + 2'd1;
    else if (!enq.valid && deq && nonempty) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (enq.valid) wptr <= !wptr;
      if (deq && nonempty) rptr <= !rptr;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (enq.valid) mem[wptr] <= enq.job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !enq.valid)
    else $error("job queue written while full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("job queue count out of range");

endmodule

>>> rtl/csn_back.sv
// csn_back: walks one job's slot mask lowest slot first, one neighbour a
// cycle into an output register while it is empty or popped.  Depends on csn_pkg.
module csn_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_nonempty,
  input  csn_pkg::job_t   q_head,
  output logic            q_deq,
  output csn_pkg::nbr_t   nbr,
  output logic            empty,
  input  logic            pop
);

  csn_pkg::job_t  cur;
  logic           cur_valid;
  logic           out_valid;
  logic [csn_pkg::STENCIL_N-1:0] low;
  logic [csn_pkg::STENCIL_N-1:0] rem;
  logic [2:0]     xs;
  logic [2:0]     ys;
  logic [2:0]     zs;
  logic           advance;
  csn_pkg::nbr_t  sel;

  assign empty   = !out_valid;
  assign advance = cur_valid && (!out_valid || pop);
  assign low     = cur.mask & (~cur.mask + csn_pkg::STENCIL_N'(1));
  assign rem     = cur.mask & ~low;
  assign q_deq   = q_nonempty && (!cur_valid || (advance && (rem == '0)));

  always_comb begin
    xs = '0;
    ys = '0;
    zs = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          xs[i] = xs[i] | low[i*9 + j*3 + k];
          ys[j] = ys[j] | low[i*9 + j*3 + k];
          zs[k] = zs[k] | low[i*9 + j*3 + k];
        end
      end
    end
    sel = '0;
    for (int i = 0; i < 3; i++) begin
      sel.nbr_x = sel.nbr_x | ({csn_pkg::COORD_W{xs[i]}} & cur.pos_x[i]);
      sel.nbr_y = sel.nbr_y | ({csn_pkg::COORD_W{ys[i]}} & cur.pos_y[i]);
      sel.nbr_z = sel.nbr_z | ({csn_pkg::COORD_W{zs[i]}} & cur.pos_z[i]);
    end
    sel.last = (rem == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;

      if (q_deq) cur_valid <= 1'b1;
      else if (advance && (rem == '0)) cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) nbr <= sel;
    if (q_deq) cur <= q_head;
    else if (advance) cur.mask <= rem;
  end

  a_cur_has_work: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.mask != '0))
    else $error("active job with no slots left");

  a_onehot_pick: assert property (@(posedge clk) disable iff (rst)
    advance |-> $onehot(low) && $onehot(xs) && $onehot(ys) && $onehot(zs))
    else $error("slot pick not one-hot");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for cell_neighbor_stencil. It predicts every neighbour word of each
// centre cell, drives the APB port and both queue sides with random gaps, and checks each word.
// Depends on csn_pkg and the rtl of cell_neighbor_stencil.
module tb;
  import csn_pkg::*;

  localparam int MAX_SIDE     = 64;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int HOLD_CYCLES  = 500;
  localparam int RANDOM_CELLS = 230;

  // Expected neighbour words plus a copy of the grid registers.
  class stencil_tracker;
    cfg_t grid;
    nbr_t nbrs_due[$];
    int   faults;

    function new();
      grid.dimensions     = RST_DIMS;
      grid.periodic_axes  = RST_PERIODIC;
      grid.cells_per_side = RST_CELLS;
      faults = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] v);
      case (idx)
        REG_DIMENSIONS: grid.dimensions = v[1:0];
        REG_PERIODIC:   grid.periodic_axes = v[1:0];
        REG_CELLS:      grid.cells_per_side = v[GRID_W-1:0];
        default: ;
      endcase
    endfunction

    // append one expected word at the tail
    function void add_due(nbr_t w);
      nbrs_due.insert(nbrs_due.size(), w);
    endfunction

    // effective grid size after clamping
    function int side();
      int n;
      n = int'(grid.cells_per_side);
      if (n < int'(MIN_CELLS)) n = int'(MIN_CELLS);
      if (n > MAX_SIDE) n = MAX_SIDE;
      return n;
    endfunction

    function int clamp_coord(logic [COORD_W-1:0] v, int n);
      return (int'(v) > n - 1) ? n - 1 : int'(v);
    endfunction

    // 0 when the step leaves the grid on a non-wrapping axis
    function bit step_axis(int c, int off, int n, bit wraps, output int p);
      p = c + off;
      if (p < 0) begin
        if (!wraps) return 1'b0;
        p = n - 1;
      end else if (p > n - 1) begin
        if (!wraps) return 1'b0;
        p = 0;
      end
      return 1'b1;
    endfunction

    function void note_cell(coord_t c);
      int   n, cx, cy, cz, zr, px, py, pz, base;
      nbr_t w;
      n = side();
      if (grid.dimensions != DIM_2D && grid.dimensions != DIM_3D) return;
      zr = (grid.dimensions == DIM_2D) ? 0 : 1;
      cx = clamp_coord(c.cell_x, n);
      cy = clamp_coord(c.cell_y, n);
      cz = (zr != 0) ? clamp_coord(c.cell_z, n) : 0;
      base = nbrs_due.size();
      for (int dx = -1; dx <= 1; dx++) begin
        if (!step_axis(cx, dx, n, grid.periodic_axes > 0, px)) continue;
        for (int dy = -1; dy <= 1; dy++) begin
          if (!step_axis(cy, dy, n, grid.periodic_axes > 1, py)) continue;
          for (int dz = -zr; dz <= zr; dz++) begin
            if (!step_axis(cz, dz, n, grid.periodic_axes > 2, pz)) continue;
            if (dx == 0 && dy == 0 && dz == 0) continue;
            w.nbr_x = px[COORD_W-1:0];
            w.nbr_y = py[COORD_W-1:0];
            w.nbr_z = pz[COORD_W-1:0];
            w.last  = 1'b0;
            add_due(w);
          end
        end
      end
      if (nbrs_due.size() > base) begin
        w = nbrs_due.pop_back();
        w.last = 1'b1;
        add_due(w);
      end
    endfunction

    function void field_check(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        faults++;
        $display("[%0t] mismatch %s: expected %0d, got %0d", $time, name, exp_v, got_v);
      end
    endfunction

    function void match_nbr(nbr_t got);
      nbr_t e;
      if (nbrs_due.size() == 0) begin
        faults++;
        $display("[%0t] unexpected word (%0d,%0d,%0d) last=%0b", $time,
                 got.nbr_x, got.nbr_y, got.nbr_z, got.last);
        return;
      end
      e = nbrs_due.pop_front();
      field_check("nbr_x", 32'(e.nbr_x), 32'(got.nbr_x));
      field_check("nbr_y", 32'(e.nbr_y), 32'(got.nbr_y));
      field_check("nbr_z", 32'(e.nbr_z), 32'(got.nbr_z));
      field_check("last", 32'(e.last), 32'(got.last));
    endfunction

    function int outstanding();
      return nbrs_due.size();
    endfunction
  endclass

  logic        clk, rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        push, full, pop, empty;
  coord_t      coord;
  nbr_t        nbr;

  stencil_tracker book = new();
  int send_idle_pct, pop_idle_pct;
  bit hold_off_req;
  int cycles = 0;

  cell_neighbor_stencil #(.MAX_CELLS_PER_SIDE(MAX_SIDE)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .push(push), .full(full), .coord(coord),
    .pop(pop), .empty(empty), .nbr(nbr)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // edges of the grid, anything in the field, or anything inside the grid
  function automatic logic [COORD_W-1:0] pick_coord(int n);
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return COORD_W'($urandom_range(0, 63));
    if (r < 7) begin
      case ($urandom_range(0, 3))
        0: return 0;
        1: return 1;
        2: return COORD_W'(n - 2);
        default: return COORD_W'(n - 1);
      endcase
    end
    return COORD_W'($urandom_range(0, n - 1));
  endfunction

  task automatic send_cell(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z);
    coord_t c;
    c.cell_x = x;
    c.cell_y = y;
    c.cell_z = z;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      repeat (pick_gap()) begin
        @(negedge clk);
        push <= 1'b0;
      end
    end
    @(negedge clk);
    push  <= 1'b1;
    coord <= c;
    do @(posedge clk); while (full);
    book.note_cell(c);
  endtask

  // wait for every expected word, then let cells with no neighbours fall through
  task automatic drain_block();
    @(negedge clk);
    push <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.write_reg(idx, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper data bits are random: the registers must ignore them
  task automatic set_grid(logic [1:0] dims, logic [1:0] per, logic [GRID_W-1:0] cells);
    logic [31:0] w;
    drain_block();
    w = $urandom;
    w[1:0] = dims;
    reg_write(REG_DIMENSIONS, w);
    w = $urandom;
    w[1:0] = per;
    reg_write(REG_PERIODIC, w);
    w = $urandom;
    w[GRID_W-1:0] = cells;
    reg_write(REG_CELLS, w);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && $urandom_range(0, 99) < pop_idle_pct) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (!rst && pop && !empty) book.match_nbr(nbr);
    end
  end

  initial begin
    int               useful, phase, quota, n, r;
    logic [1:0]       d, p;
    logic [GRID_W-1:0] s;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    push = 1'b0;
    coord = '0;
    send_idle_pct = 20;
    pop_idle_pct = 20;
    hold_off_req = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset grid, extremes, wrap settings, clamped sizes, dead dimension codes
    send_cell(0, 0, 0);
    send_cell(63, 63, 63);
    send_cell(1, 1, 1);
    set_grid(DIM_2D, 2'd0, 7'd64);
    send_cell(0, 0, 63);
    send_cell(63, 63, 0);
    send_cell(31, 17, 5);
    set_grid(DIM_3D, 2'd3, 7'd64);
    send_cell(0, 0, 0);
    send_cell(63, 63, 63);
    send_cell(1, 62, 42);
    set_grid(DIM_3D, 2'd1, 7'd0);
    send_cell(2, 0, 1);
    send_cell(21, 42, 21);
    set_grid(DIM_3D, 2'd2, 7'd127);
    send_cell(0, 63, 0);
    send_cell(63, 0, 63);
    set_grid(DIM_2D, 2'd3, 7'd3);
    send_cell(0, 0, 63);
    send_cell(2, 2, 0);
    set_grid(2'd0, 2'd3, 7'd10);
    send_cell(1, 1, 1);
    set_grid(2'd1, 2'd0, 7'd10);
    send_cell(2, 2, 2);

    useful = 0;
    phase = 0;
    while (useful < RANDOM_CELLS) begin
      r = $urandom_range(0, 99);
      d = (r < 10) ? 2'($urandom_range(0, 1)) : 2'($urandom_range(2, 3));
      p = 2'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 8) s = GRID_W'($urandom_range(0, 2));
      else if (r < 16) s = GRID_W'($urandom_range(65, 127));
      else if (r < 40) s = ($urandom_range(0, 1) != 0) ? 7'd3 : 7'd64;
      else s = GRID_W'($urandom_range(3, 64));
      if (phase == 0) begin
        d = DIM_3D;
        p = 2'd3;
        s = 7'd64;
      end else if (phase == 1) begin
        d = DIM_2D;
        p = 2'd0;
        s = 7'd3;
      end else if (phase == 2) begin
        d = DIM_3D;
        s = 7'd64;
      end
      set_grid(d, p, s);
      n = book.side();
      if ($urandom_range(0, 3) == 0) begin
        send_idle_pct = 0;
        pop_idle_pct = 0;
      end else begin
        send_idle_pct = $urandom_range(10, 50);
        pop_idle_pct = $urandom_range(5, 40);
      end
      // long receiver hold-off while cells keep coming, so full must rise
      if (phase == 2) begin
        send_idle_pct = 0;
        hold_off_req = 1'b1;
      end
      quota = (d < DIM_2D) ? 4 : 23;
      for (int k = 0; k < quota; k++) begin
        if (phase == 4 && k == 10) drain_block();
        send_cell(pick_coord(n), pick_coord(n), pick_coord(n));
        if (d >= DIM_2D) useful++;
      end
      phase++;
    end
    drain_block();

    if (book.faults == 0 && book.outstanding() == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
